[sv/bbn_pkg.sv]
// Shared types and constants of the bounding-box normalizer.
package bbn_pkg;

    // Geometry and arithmetic widths
    localparam int AXES        = 3;
    localparam int AX_W        = $clog2(AXES);
    localparam int ISS_W       = $clog2(AXES + 1);
    localparam int COORD_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int SCALE_W     = 48;
    localparam int HALF_W      = SCALE_W / 2;
    localparam int SCALE_SHIFT = 47;
    localparam int OUT_SHIFT   = 17;
    localparam int DIFF_W      = COORD_W + 3;
    localparam int MAG_W       = COORD_W + 2;
    localparam int PROD_W      = MAG_W + HALF_W;
    localparam int RES_W       = PROD_W - OUT_SHIFT + 2;
    localparam int EXT_W       = COORD_W;

    // Function codes carried in the input tuser
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_XFORM = 2'd2;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // Classified item kind in the queue
    typedef enum logic [1:0] {
        K_CLEAR,
        K_ACC,
        K_XFORM
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ZERO_EXT = 2'd2
    } t_status;

    // Queued item
    typedef struct packed {
        t_kind                          kind;
        logic [AXES-1:0][COORD_W-1:0]   pos;
    } t_item;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXT,
        S_DIV,
        S_NORM,
        S_DONE
    } t_bstate;

endpackage

[sv/bbn_front.sv]
// Front end: accepts items, classifies the function code, queues them.
module bbn_front #(
    parameter int DEPTH = 4
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [bbn_pkg::FUNC_W-1:0]                    i_func,
    input  logic [bbn_pkg::AXES-1:0][bbn_pkg::COORD_W-1:0] i_pos,
    output logic                                          o_item_vld,
    output bbn_pkg::t_item                                o_item,
    input  logic                                          i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bbn_pkg::t_item     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;

    logic               acc;
    logic               push;
    bbn_pkg::t_item     w_item;

    // Classify: unused codes are accepted and dropped
    always_comb begin
        w_item.pos = i_pos;
        w_item.kind = bbn_pkg::K_CLEAR;
        push = 1'b0;
        acc = i_valid && o_ready;
        unique case (i_func)
            bbn_pkg::FUNC_CLEAR: begin
                w_item.kind = bbn_pkg::K_CLEAR;
                push = acc;
            end
            bbn_pkg::FUNC_ACC: begin
                w_item.kind = bbn_pkg::K_ACC;
                push = acc;
            end
            bbn_pkg::FUNC_XFORM: begin
                w_item.kind = bbn_pkg::K_XFORM;
                push = acc;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    assign o_ready    = (r_cnt != CNT_W'(DEPTH));
    assign o_item_vld = (r_cnt != '0);
    assign o_item     = r_mem[r_rd];

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(i_pop);
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= w_item;
        end
    end

endmodule

[sv/bbn_div.sv]
// Scale divider: round(2^47 / extent), one quotient bit per cycle.
module bbn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bbn_pkg::EXT_W-1:0]     i_den,
    output logic                          o_done,
    output logic [bbn_pkg::SCALE_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(bbn_pkg::SCALE_W);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [bbn_pkg::EXT_W-1:0]      r_den;
    logic [bbn_pkg::EXT_W-1:0]      r_rem;
    logic [bbn_pkg::SCALE_W-1:0]    r_num;

    logic [bbn_pkg::EXT_W:0]        trial;
    logic                           fits;
    logic [bbn_pkg::EXT_W-1:0]      n_rem;
    logic [bbn_pkg::SCALE_W-1:0]    start_num;

    // One restoring step; the quotient shifts in where the numerator leaves
    always_comb begin
        trial = {r_rem, r_num[bbn_pkg::SCALE_W-1]};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? bbn_pkg::EXT_W'(trial - {1'b0, r_den})
                     : bbn_pkg::EXT_W'(trial);
        start_num = (bbn_pkg::SCALE_W'(1) << bbn_pkg::SCALE_SHIFT)
                  + bbn_pkg::SCALE_W'(i_den >> 1);
    end

    // Done is raised the cycle after the last step, when the quotient is complete
    assign o_done = r_done;
    assign o_quot = r_num;

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(bbn_pkg::SCALE_W - 1);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_num <= start_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[bbn_pkg::SCALE_W-2:0], fits};
        end
    end

endmodule

[sv/bbn_back.sv]
// Back end: box state, scale latch, per-axis normalize pipeline, result register.
module bbn_back (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_item_vld,
    input  bbn_pkg::t_item                                 i_item,
    output logic                                           o_pop,
    output logic                                           o_valid,
    input  logic                                           i_ready,
    output logic [bbn_pkg::AXES-1:0][bbn_pkg::COORD_W-1:0] o_norm,
    output logic [bbn_pkg::STATUS_W-1:0]                   o_status
);

    localparam logic [bbn_pkg::RES_W-1:0] SAT_NEG =
        bbn_pkg::RES_W'(1) << (bbn_pkg::COORD_W - 1);
    localparam logic [bbn_pkg::RES_W-1:0] SAT_POS = SAT_NEG - 1'b1;
    localparam logic [bbn_pkg::PROD_W-1:0] RND =
        bbn_pkg::PROD_W'(1) << (bbn_pkg::OUT_SHIFT - 1);

    bbn_pkg::t_bstate r_state, n_state;

    // Box state
    logic signed [bbn_pkg::COORD_W-1:0]  r_min [bbn_pkg::AXES];
    logic signed [bbn_pkg::COORD_W-1:0]  r_max [bbn_pkg::AXES];
    logic                                r_filled;
    logic                                r_ready;
    logic [bbn_pkg::SCALE_W-1:0]         r_scale;

    // Current transform
    logic signed [bbn_pkg::COORD_W-1:0]  r_pos  [bbn_pkg::AXES];
    logic [bbn_pkg::COORD_W-1:0]         r_norm [bbn_pkg::AXES];
    bbn_pkg::t_status                    r_res_status;

    // Normalize pipeline
    logic [bbn_pkg::ISS_W-1:0]           r_iss;
    logic                                r_s1_vld, r_s2_vld;
    logic [bbn_pkg::AX_W-1:0]            r_s1_ax, r_s2_ax;
    logic [bbn_pkg::MAG_W-1:0]           r_s1_mag;
    logic                                r_s1_neg, r_s2_neg;
    logic [bbn_pkg::PROD_W-1:0]          r_s2_a, r_s2_b;

    // Result register
    logic                                r_out_vld;
    logic [bbn_pkg::COORD_W-1:0]         r_out_norm [bbn_pkg::AXES];
    bbn_pkg::t_status                    r_out_status;

    logic                                issue, out_free, out_load, last_fin;
    logic                                div_start, div_done;
    logic [bbn_pkg::SCALE_W-1:0]         div_quot;
    logic [bbn_pkg::EXT_W-1:0]           ext;
    logic                                ext_zero;
    logic [bbn_pkg::AX_W-1:0]            iss_ax;
    logic signed [bbn_pkg::DIFF_W-1:0]   s0_d, s0_abs;
    logic [bbn_pkg::RES_W-1:0]           f_r, f_clamp;
    logic [bbn_pkg::COORD_W-1:0]         f_out;

    // Largest extent over the axes
    always_comb begin
        logic signed [bbn_pkg::COORD_W:0] e;
        ext = '0;
        for (int a = 0; a < bbn_pkg::AXES; a++) begin
            e = (bbn_pkg::COORD_W + 1)'(r_max[a]) - (bbn_pkg::COORD_W + 1)'(r_min[a]);
            if (e[bbn_pkg::EXT_W-1:0] > ext) begin
                ext = e[bbn_pkg::EXT_W-1:0];
            end
        end
        ext_zero = (ext == '0);
    end

    bbn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (ext),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Stage 0: d = 2p - (min + max), split into sign and magnitude
    always_comb begin
        iss_ax = r_iss[bbn_pkg::AX_W-1:0];
        s0_d = (bbn_pkg::DIFF_W'(r_pos[iss_ax]) <<< 1)
             - (bbn_pkg::DIFF_W'(r_min[iss_ax]) + bbn_pkg::DIFF_W'(r_max[iss_ax]));
        s0_abs = s0_d[bbn_pkg::DIFF_W-1] ? -s0_d : s0_d;
    end

    // Stage 2: recombine partial products, round, saturate
    always_comb begin
        if (|r_s2_a[bbn_pkg::PROD_W-1:bbn_pkg::HALF_W]) begin
            f_r = bbn_pkg::RES_W'(1) << bbn_pkg::COORD_W;
        end else begin
            f_r = (bbn_pkg::RES_W'(r_s2_a[bbn_pkg::HALF_W-1:0])
                      << (bbn_pkg::HALF_W - bbn_pkg::OUT_SHIFT))
                + bbn_pkg::RES_W'((r_s2_b + RND) >> bbn_pkg::OUT_SHIFT);
        end
        if (r_s2_neg) begin
            f_clamp = (f_r > SAT_NEG) ? SAT_NEG : f_r;
            f_out   = bbn_pkg::COORD_W'(bbn_pkg::RES_W'(0) - f_clamp);
        end else begin
            f_clamp = (f_r > SAT_POS) ? SAT_POS : f_r;
            f_out   = f_clamp[bbn_pkg::COORD_W-1:0];
        end
    end

    assign out_free = !r_out_vld || i_ready;
    assign last_fin = r_s2_vld && (r_s2_ax == bbn_pkg::AX_W'(bbn_pkg::AXES - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbn_pkg::S_IDLE: begin
                if (i_item_vld && i_item.kind == bbn_pkg::K_XFORM) begin
                    priority if (!r_filled)         n_state = bbn_pkg::S_DONE;
                    else if (!r_ready)              n_state = bbn_pkg::S_EXT;
                    else if (r_scale == '0)         n_state = bbn_pkg::S_DONE;
                    else                            n_state = bbn_pkg::S_NORM;
                end
            end
            bbn_pkg::S_EXT:  n_state = ext_zero ? bbn_pkg::S_DONE : bbn_pkg::S_DIV;
            bbn_pkg::S_DIV:  if (div_done) n_state = bbn_pkg::S_NORM;
            bbn_pkg::S_NORM: if (last_fin) n_state = bbn_pkg::S_DONE;
            bbn_pkg::S_DONE: if (out_free) n_state = bbn_pkg::S_IDLE;
            default:         n_state = bbn_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop     = (r_state == bbn_pkg::S_IDLE) && i_item_vld;
        div_start = (r_state == bbn_pkg::S_EXT) && !ext_zero;
        issue     = (r_state == bbn_pkg::S_NORM) && (r_iss != bbn_pkg::ISS_W'(bbn_pkg::AXES));
        out_load  = (r_state == bbn_pkg::S_DONE) && out_free;
    end

    // Control and box state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bbn_pkg::S_IDLE;
            r_filled  <= 1'b0;
            r_ready   <= 1'b0;
            r_scale   <= '0;
            r_iss     <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int a = 0; a < bbn_pkg::AXES; a++) begin
                r_min[a] <= bbn_pkg::COORD_MAX;
                r_max[a] <= bbn_pkg::COORD_MIN;
            end
        end else begin
            r_state  <= n_state;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (issue) begin
                r_iss <= r_iss + 1'b1;
            end else if (r_state != bbn_pkg::S_NORM) begin
                r_iss <= '0;
            end
            if (o_pop) begin
                unique case (i_item.kind)
                    bbn_pkg::K_CLEAR: begin
                        r_filled <= 1'b0;
                        r_ready  <= 1'b0;
                        r_scale  <= '0;
                        for (int a = 0; a < bbn_pkg::AXES; a++) begin
                            r_min[a] <= bbn_pkg::COORD_MAX;
                            r_max[a] <= bbn_pkg::COORD_MIN;
                        end
                    end
                    bbn_pkg::K_ACC: begin
                        r_filled <= 1'b1;
                        r_ready  <= 1'b0;
                        for (int a = 0; a < bbn_pkg::AXES; a++) begin
                            if ($signed(i_item.pos[a]) < r_min[a]) r_min[a] <= i_item.pos[a];
                            if ($signed(i_item.pos[a]) > r_max[a]) r_max[a] <= i_item.pos[a];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == bbn_pkg::S_EXT && ext_zero) begin
                r_scale <= '0;
                r_ready <= 1'b1;
            end
            if (div_done) begin
                r_scale <= div_quot;
                r_ready <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Transform payload and pipeline data
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.kind == bbn_pkg::K_XFORM) begin
            for (int a = 0; a < bbn_pkg::AXES; a++) begin
                r_pos[a]  <= i_item.pos[a];
                r_norm[a] <= '0;
            end
            priority if (!r_filled)                  r_res_status <= bbn_pkg::ST_EMPTY;
            else if (r_ready && r_scale == '0)       r_res_status <= bbn_pkg::ST_ZERO_EXT;
            else                                     r_res_status <= bbn_pkg::ST_OK;
        end
        if (r_state == bbn_pkg::S_EXT && ext_zero) begin
            r_res_status <= bbn_pkg::ST_ZERO_EXT;
        end
        if (issue) begin
            r_s1_ax  <= iss_ax;
            r_s1_neg <= s0_d[bbn_pkg::DIFF_W-1];
            r_s1_mag <= s0_abs[bbn_pkg::MAG_W-1:0];
        end
        if (r_s1_vld) begin
            r_s2_ax  <= r_s1_ax;
            r_s2_neg <= r_s1_neg;
            r_s2_a   <= bbn_pkg::PROD_W'(r_s1_mag)
                      * bbn_pkg::PROD_W'(r_scale[bbn_pkg::SCALE_W-1:bbn_pkg::HALF_W]);
            r_s2_b   <= bbn_pkg::PROD_W'(r_s1_mag)
                      * bbn_pkg::PROD_W'(r_scale[bbn_pkg::HALF_W-1:0]);
        end
        if (r_s2_vld) begin
            r_norm[r_s2_ax] <= f_out;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            for (int a = 0; a < bbn_pkg::AXES; a++) begin
                r_out_norm[a] <= r_norm[a];
            end
        end
    end

    // Result port
    assign o_valid  = r_out_vld;
    assign o_status = r_out_status;
    always_comb begin
        for (int a = 0; a < bbn_pkg::AXES; a++) begin
            o_norm[a] = r_out_norm[a];
        end
    end

`ifndef SYNTHESIS
    // Divider completes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == bbn_pkg::S_DIV)
        else $error("divider done outside divide state");

    // Normalize pipeline only runs with a latched scale
    a_pipe_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_state == bbn_pkg::S_NORM) && r_ready && (r_scale != '0))
        else $error("normalize stage active without a valid scale");

    // Accumulate marks the box filled and the scale stale
    a_acc_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.kind == bbn_pkg::K_ACC) |=> r_filled && !r_ready)
        else $error("accumulate left the scale marked ready");

    // No new item is taken while a transform is in flight
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbn_pkg::S_DIV || r_state == bbn_pkg::S_NORM) |-> !o_pop)
        else $error("queue popped during a transform");
`endif

endmodule

[sv/bounding_box_normalizer.sv]
// Top level of the bounding-box normalizer: front queue plus back end.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: pos_x,pos_y,pos_z  tuser: func
//  m_axis    out  m_axis_tvalid/tready        tdata: norm_x,norm_y,norm_z  tuser: status
//
// Clear and accumulate are taken by the back end straight from idle; a transform with a latched
// scale passes pop, the per-axis normalize pipeline and the result load, while
// an empty-box or zero-extent transform skips the pipeline.
// The first transform after an accumulate first computes the scale: it picks the
// largest extent and, if it is nonzero, runs 48 divider steps for the 48-bit quotient and hands it over.
// The input queue keeps accepting, until it is full, while the back end works or the output stalls.
// Reset is synchronous, active low; it empties the queue and resets the box.
module bounding_box_normalizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] norm_x, [63:32] norm_y, [95:64] norm_z
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic                                           q_vld;
    bbn_pkg::t_item                                 q_item;
    logic                                           q_pop;
    logic [bbn_pkg::AXES-1:0][bbn_pkg::COORD_W-1:0] in_pos;
    logic [bbn_pkg::AXES-1:0][bbn_pkg::COORD_W-1:0] out_norm;

    assign in_pos       = s_axis_tdata;
    assign m_axis_tdata = out_norm;

    bbn_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_pos      (in_pos),
        .o_item_vld (q_vld),
        .o_item     (q_item),
        .i_pop      (q_pop)
    );

    bbn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_vld (q_vld),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_norm     (out_norm),
        .o_status   (m_axis_tuser)
    );

endmodule
